[hw/rtl/tfn_pkg.sv]
`default_nettype none
package tfn_pkg;

    localparam int IDX_W      = 10;
    localparam int POS_W      = 24;
    localparam int NRM_W      = 16;
    localparam int EDGE_W     = 25;
    localparam int CROSS_W    = 51;
    localparam int MAG_W      = 30;
    localparam int SUM_W      = 62;
    localparam int HALF_W     = 31;
    localparam int SEARCH_W   = 15;
    localparam int SLOT_CNT_W = 17;
    localparam int IDX_SPAN   = 1024;

    // Largest magnitude of a normal component: 1.0 in Q1.14.
    localparam logic [SEARCH_W-1:0] UNIT_ONE = 15'd16384;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [NRM_W-1:0] nrm_t;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef struct packed {
        pos_t z;
        pos_t y;
        pos_t x;
    } vertex_t;

    typedef struct packed {
        nrm_t z;
        nrm_t y;
        nrm_t x;
    } normal_vec_t;

    typedef struct packed {
        logic        degenerate;
        normal_vec_t vec;
    } normal_res_t;

endpackage
`default_nettype wire

[hw/rtl/tfn_cmd_if.sv]
`default_nettype none
interface tfn_cmd_if;
    import tfn_pkg::*;

    logic valid;
    logic ready;
    op_t  op;
    idx_t first_index;
    idx_t second_index;
    idx_t third_index;
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;

    modport source (
        output valid, op, first_index, second_index, third_index, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, op, first_index, second_index, third_index, pos_x, pos_y, pos_z,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/tfn_res_if.sv]
`default_nettype none
interface tfn_res_if;
    import tfn_pkg::*;

    logic valid;
    logic ready;
    nrm_t normal_x;
    nrm_t normal_y;
    nrm_t normal_z;
    logic degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface
`default_nettype wire

[hw/rtl/tfn_normal_unit.sv]
`default_nettype none
module tfn_normal_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tfn_pkg::vertex_t     p0,
    input  tfn_pkg::vertex_t     p1,
    input  tfn_pkg::vertex_t     p2,
    output logic                 done,
    output tfn_pkg::normal_res_t res
);
    import tfn_pkg::*;

    localparam int CMP_W = 3 * HALF_W;

    typedef enum logic [8:0] {
        U_IDLE  = 9'b000000001,
        U_CROSS = 9'b000000010,
        U_MAG   = 9'b000000100,
        U_SHIFT = 9'b000001000,
        U_SUM   = 9'b000010000,
        U_TSQ   = 9'b000100000,
        U_PLO   = 9'b001000000,
        U_PHI   = 9'b010000000,
        U_CMP   = 9'b100000000
    } ustate_t;

    ustate_t state_reg;
    ustate_t state_next;

    logic signed [EDGE_W-1:0]   e1_reg [3];
    logic signed [EDGE_W-1:0]   e2_reg [3];
    logic signed [2*EDGE_W-1:0] prod_reg;
    logic signed [CROSS_W-1:0]  c_reg [3];
    logic [CROSS_W-1:0]         mag_reg [3];
    logic [2:0]                 neg_reg;
    logic [2:0]                 cnt_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [2*MAG_W-1:0]         sq_reg [3];
    logic [2*HALF_W-1:0]        mul_reg;
    logic [2*HALF_W-1:0]        plo_reg;
    logic [MAG_W-1:0]           t_reg;
    logic [SEARCH_W-1:0]        lo_reg;
    logic [SEARCH_W-1:0]        hi_reg;
    logic [SEARCH_W-1:0]        mid_reg;
    logic [1:0]                 comp_reg;
    nrm_t                       n_reg [3];
    logic                       degen_reg;
    logic                       done_reg;

    logic signed [EDGE_W-1:0] xa;
    logic signed [EDGE_W-1:0] xb;
    logic [HALF_W-1:0]        mul_a;
    logic [HALF_W-1:0]        mul_b;
    logic [2:0]               cnt_m1;
    logic [CROSS_W-1:0]       mag_or;
    logic                     c_zero;
    logic [SEARCH_W:0]        mid_sum;
    logic [SEARCH_W-1:0]      mid_next;
    logic [SEARCH_W:0]        odd;
    logic [MAG_W-1:0]         sum_mag;
    logic [CMP_W-1:0]         lhs;
    logic [CMP_W-1:0]         rhs;
    logic [SEARCH_W-1:0]      cur_mag;

    assign cnt_m1   = cnt_reg - 3'd1;
    assign mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign c_zero   = (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + 16'd1;
    assign mid_next = mid_sum[SEARCH_W:1];
    assign odd      = {mid_next, 1'b0} - 16'd1;
    assign lhs      = {mul_reg, {HALF_W{1'b0}}} + CMP_W'(plo_reg);
    assign rhs      = CMP_W'({sq_reg[comp_reg], {MAG_W{1'b0}}});
    assign cur_mag  = lo_reg;

    // Operand order for the six partial products of e1 x e2.
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin xa = e1_reg[1]; xb = e2_reg[2]; end
            3'd1:    begin xa = e1_reg[2]; xb = e2_reg[1]; end
            3'd2:    begin xa = e1_reg[2]; xb = e2_reg[0]; end
            3'd3:    begin xa = e1_reg[0]; xb = e2_reg[2]; end
            3'd4:    begin xa = e1_reg[0]; xb = e2_reg[1]; end
            default: begin xa = e1_reg[1]; xb = e2_reg[0]; end
        endcase
    end

    always_comb
    begin
        case (cnt_reg)
            3'd1:    sum_mag = mag_reg[1][MAG_W-1:0];
            3'd2:    sum_mag = mag_reg[2][MAG_W-1:0];
            default: sum_mag = mag_reg[0][MAG_W-1:0];
        endcase
    end

    // One shared unsigned multiplier for squares and the bisection products.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            U_SUM:
            begin
                mul_a = HALF_W'(sum_mag);
                mul_b = HALF_W'(sum_mag);
            end
            U_TSQ:
            begin
                mul_a = HALF_W'(odd);
                mul_b = HALF_W'(odd);
            end
            U_PLO:
            begin
                mul_a = mul_reg[HALF_W-1:0];
                mul_b = sum_reg[HALF_W-1:0];
            end
            U_PHI:
            begin
                mul_a = HALF_W'(t_reg);
                mul_b = sum_reg[SUM_W-1:HALF_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            U_IDLE:  if (start) state_next = U_CROSS;
            U_CROSS: if (cnt_reg == 3'd6) state_next = U_MAG;
            U_MAG:   state_next = c_zero ? U_IDLE : U_SHIFT;
            U_SHIFT: if (mag_or[CROSS_W-1:MAG_W] == '0) state_next = U_SUM;
            U_SUM:   if (cnt_reg == 3'd3) state_next = U_TSQ;
            U_TSQ:
            begin
                if (lo_reg != hi_reg)
                    state_next = U_PLO;
                else if (comp_reg == 2'd2)
                    state_next = U_IDLE;
            end
            U_PLO:   state_next = U_PHI;
            U_PHI:   state_next = U_CMP;
            U_CMP:   state_next = U_TSQ;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == U_MAG) && c_zero)
                      || ((state_reg == U_TSQ) && (lo_reg == hi_reg) && (comp_reg == 2'd2));
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg  <= mul_a * mul_b;
        prod_reg <= xa * xb;
        case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    e1_reg[0] <= EDGE_W'(p1.x) - EDGE_W'(p0.x);
                    e1_reg[1] <= EDGE_W'(p1.y) - EDGE_W'(p0.y);
                    e1_reg[2] <= EDGE_W'(p1.z) - EDGE_W'(p0.z);
                    e2_reg[0] <= EDGE_W'(p2.x) - EDGE_W'(p0.x);
                    e2_reg[1] <= EDGE_W'(p2.y) - EDGE_W'(p0.y);
                    e2_reg[2] <= EDGE_W'(p2.z) - EDGE_W'(p0.z);
                    for (int j = 0; j < 3; j++)
                        c_reg[j] <= '0;
                    cnt_reg <= '0;
                end
            end
            U_CROSS:
            begin
                // The registered product of the previous count value lands here.
                if (cnt_reg != 3'd0)
                begin
                    if (cnt_m1[0] == 1'b0)
                        c_reg[cnt_m1[2:1]] <= c_reg[cnt_m1[2:1]] + CROSS_W'(prod_reg);
                    else
                        c_reg[cnt_m1[2:1]] <= c_reg[cnt_m1[2:1]] - CROSS_W'(prod_reg);
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
            U_MAG:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    neg_reg[j] <= c_reg[j][CROSS_W-1];
                    mag_reg[j] <= c_reg[j][CROSS_W-1] ? CROSS_W'(-c_reg[j]) : CROSS_W'(c_reg[j]);
                    n_reg[j]   <= '0;
                end
                degen_reg <= c_zero;
                sum_reg   <= '0;
                cnt_reg   <= '0;
            end
            U_SHIFT:
            begin
                if (mag_or[CROSS_W-1:MAG_W] != '0)
                    for (int j = 0; j < 3; j++)
                        mag_reg[j] <= mag_reg[j] >> 1;
            end
            U_SUM:
            begin
                if (cnt_reg != 3'd0)
                begin
                    sum_reg <= sum_reg + SUM_W'(mul_reg);
                    sq_reg[cnt_m1[1:0]] <= mul_reg[2*MAG_W-1:0];
                end
                cnt_reg  <= cnt_reg + 3'd1;
                comp_reg <= '0;
                lo_reg   <= '0;
                hi_reg   <= UNIT_ONE;
            end
            U_TSQ:
            begin
                if (lo_reg != hi_reg)
                    mid_reg <= mid_next;
                else
                begin
                    n_reg[comp_reg] <= neg_reg[comp_reg] ? -NRM_W'(cur_mag) : NRM_W'(cur_mag);
                    comp_reg <= comp_reg + 2'd1;
                    lo_reg   <= '0;
                    hi_reg   <= UNIT_ONE;
                end
            end
            U_PLO:
                t_reg <= mul_reg[MAG_W-1:0];
            U_PHI:
                plo_reg <= mul_reg;
            U_CMP:
            begin
                // Round up to mid while (2mid-1)^2 * S <= a^2 * 2^30.
                if (lhs <= rhs)
                    lo_reg <= mid_reg;
                else
                    hi_reg <= mid_reg - 15'd1;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign done           = done_reg;
    assign res.degenerate = degen_reg;
    assign res.vec.x      = n_reg[0];
    assign res.vec.y      = n_reg[1];
    assign res.vec.z      = n_reg[2];

endmodule
`default_nettype wire

[hw/rtl/triangle_face_normal_store.sv]
// Vertex position and normal store. A load transaction returns nothing; a
// read transaction returns the stored normal through ST_READ_N and ST_EMIT;
// a triangle transaction runs the normal unit, which ends without bisection
// when the cross product is zero and otherwise bisects each of the three
// unit normal components with one shared 31x31 multiplier, each step passing
// U_TSQ, U_PLO, U_PHI and U_CMP, after shifting the magnitudes right by up
// to twenty-one bits. Items are processed one at a time. After reset the block
// clears the normal memory, one entry a cycle, over all min(VERTEX_SLOTS, 1024)
// entries, and accepts no transaction during that pass.
`default_nettype none
module triangle_face_normal_store #(
    parameter int VERTEX_SLOTS = 1024
) (
    input  logic clk,
    input  logic rst_n,
    tfn_cmd_if.sink   cmd,
    tfn_res_if.source res
);
    import tfn_pkg::*;

    localparam int DEPTH  = (VERTEX_SLOTS < IDX_SPAN) ? VERTEX_SLOTS : IDX_SPAN;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b00000000001,
        ST_IDLE   = 11'b00000000010,
        ST_READ_N = 11'b00000000100,
        ST_POS0   = 11'b00000001000,
        ST_POS1   = 11'b00000010000,
        ST_POS2   = 11'b00000100000,
        ST_CALC   = 11'b00001000000,
        ST_WR0    = 11'b00010000000,
        ST_WR1    = 11'b00100000000,
        ST_WR2    = 11'b01000000000,
        ST_EMIT   = 11'b10000000000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    idx_t        idx_reg [3];
    logic [2:0]  ok_reg;
    vertex_t     p_reg [3];
    normal_res_t res_reg;
    logic        out_valid_reg;
    normal_res_t out_reg;
    logic        start_reg;

    vertex_t     pos_mem [DEPTH];
    vertex_t     pos_q_reg;
    normal_vec_t nrm_mem [DEPTH];
    normal_vec_t nrm_q_reg;

    logic              accept;
    logic              first_ok;
    logic              pos_we;
    logic [ADDR_W-1:0] pos_raddr;
    logic              nrm_we;
    logic [ADDR_W-1:0] nrm_waddr;
    normal_vec_t       nrm_wdata;
    logic              out_load;
    logic              unit_done;
    normal_res_t       unit_res;

    function automatic logic in_range(input idx_t idx);
        return SLOT_CNT_W'(idx) < SLOT_CNT_W'(VERTEX_SLOTS);
    endfunction

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign first_ok  = in_range(cmd.first_index);
    assign pos_we    = accept && (cmd.op == OP_LOAD) && first_ok;
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || res.ready);

    always_comb
    begin
        case (state_reg)
            ST_POS0: pos_raddr = idx_reg[1][ADDR_W-1:0];
            ST_POS1: pos_raddr = idx_reg[2][ADDR_W-1:0];
            default: pos_raddr = cmd.first_index[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        nrm_we    = 1'b0;
        nrm_waddr = cmd.first_index[ADDR_W-1:0];
        nrm_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                nrm_we    = 1'b1;
                nrm_waddr = clr_cnt_reg;
            end
            ST_IDLE:
                nrm_we = pos_we;
            ST_WR0:
            begin
                nrm_we    = ok_reg[0];
                nrm_waddr = idx_reg[0][ADDR_W-1:0];
                nrm_wdata = res_reg.vec;
            end
            ST_WR1:
            begin
                nrm_we    = ok_reg[1];
                nrm_waddr = idx_reg[1][ADDR_W-1:0];
                nrm_wdata = res_reg.vec;
            end
            ST_WR2:
            begin
                nrm_we    = ok_reg[2];
                nrm_waddr = idx_reg[2][ADDR_W-1:0];
                nrm_wdata = res_reg.vec;
            end
            default:
                nrm_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[cmd.first_index[ADDR_W-1:0]] <= '{z: cmd.pos_z, y: cmd.pos_y, x: cmd.pos_x};
        pos_q_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nrm_we)
            nrm_mem[nrm_waddr] <= nrm_wdata;
        nrm_q_reg <= nrm_mem[cmd.first_index[ADDR_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        OP_TRIANGLE: state_next = ST_POS0;
                        OP_READ:     state_next = ST_READ_N;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ_N: state_next = ST_EMIT;
            ST_POS0:   state_next = ST_POS1;
            ST_POS1:   state_next = ST_POS2;
            ST_POS2:   state_next = ST_CALC;
            ST_CALC:   if (unit_done) state_next = ST_WR0;
            ST_WR0:    state_next = ST_WR1;
            ST_WR1:    state_next = ST_WR2;
            ST_WR2:    state_next = ST_EMIT;
            ST_EMIT:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            start_reg <= (state_reg == ST_POS2);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_reg[0] <= cmd.first_index;
                    idx_reg[1] <= cmd.second_index;
                    idx_reg[2] <= cmd.third_index;
                    ok_reg     <= {in_range(cmd.third_index), in_range(cmd.second_index),
                                   first_ok};
                end
            end
            ST_READ_N:
            begin
                res_reg.vec        <= ok_reg[0] ? nrm_q_reg : '0;
                res_reg.degenerate <= 1'b0;
            end
            ST_POS0: p_reg[0] <= ok_reg[0] ? pos_q_reg : '0;
            ST_POS1: p_reg[1] <= ok_reg[1] ? pos_q_reg : '0;
            ST_POS2: p_reg[2] <= ok_reg[2] ? pos_q_reg : '0;
            ST_CALC: if (unit_done) res_reg <= unit_res;
            default: res_reg <= res_reg;
        endcase
        if (out_load)
            out_reg <= res_reg;
    end

    tfn_normal_unit u_normal (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .p0    (p_reg[0]),
        .p1    (p_reg[1]),
        .p2    (p_reg[2]),
        .done  (unit_done),
        .res   (unit_res)
    );

    assign res.valid      = out_valid_reg;
    assign res.normal_x   = out_reg.vec.x;
    assign res.normal_y   = out_reg.vec.y;
    assign res.normal_z   = out_reg.vec.z;
    assign res.degenerate = out_reg.degenerate;

endmodule
`default_nettype wire
